// ===== hw/rtl/cfir_pkg.sv =====
// ----------------------------------------------------------------------------
// cfir_pkg
// Shared types and constants for the causal convolution FIR filter.
// ----------------------------------------------------------------------------
package cfir_pkg;

    localparam int TAPS   = 1024;
    localparam int IDX_W  = 10;
    localparam int TAP_W  = 16;
    localparam int SMP_W  = 16;
    localparam int OUT_W  = 48;
    localparam int ADDR_W = $clog2(TAPS);
    localparam int CNT_W  = $clog2(TAPS + 1);
    localparam int PROD_W = TAP_W + SMP_W + 1;
    localparam int ACC_W  = (PROD_W + CNT_W > OUT_W + 1) ? PROD_W + CNT_W : OUT_W + 1;
    localparam int CMP_W  = ((IDX_W > ADDR_W) ? IDX_W : ADDR_W) + 1;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_PUSH  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

    typedef struct packed {
        logic [1:0]              command;
        logic [IDX_W-1:0]        tap_index;
        logic signed [TAP_W-1:0] tap_value;
        logic [SMP_W-1:0]        sample_value;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] filtered_value;
        logic [IDX_W-1:0]        sample_position;
    } t_out_item;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_DONE
    } t_state;

endpackage

// ===== hw/rtl/cfir_ram.sv =====
// ----------------------------------------------------------------------------
// cfir_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module cfir_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/cfir_mac.sv =====
// ----------------------------------------------------------------------------
// cfir_mac
// Pipelined multiply-accumulate unit with a saturated 48-bit result.
// ----------------------------------------------------------------------------
module cfir_mac
    import cfir_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_mac_ctl                 i_ctl,
    input  logic signed [TAP_W-1:0]  i_kernel,
    input  logic [SMP_W-1:0]         i_sample,
    output logic                     o_done,
    output logic signed [OUT_W-1:0]  o_sum
);

    t_mac_ctl                  r_pctl;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACC_W-1:0]   n_acc;
    logic                      r_done;

    always_comb begin
        n_acc = r_acc;
        if (r_pctl.valid) begin
            n_acc = (r_pctl.first ? ACC_W'(0) : r_acc) + ACC_W'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pctl <= '0;
            r_done <= 1'b0;
        end else begin
            r_pctl <= i_ctl;
            r_done <= r_pctl.valid && r_pctl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_kernel * $signed({1'b0, i_sample});
        r_acc  <= n_acc;
    end

    always_comb begin
        if (r_acc > ACC_W'(OUT_MAX)) begin
            o_sum = OUT_MAX;
        end else if (r_acc < ACC_W'(OUT_MIN)) begin
            o_sum = OUT_MIN;
        end else begin
            o_sum = OUT_W'(r_acc);
        end
    end

    assign o_done = r_done;

endmodule

// ===== hw/rtl/causal_convolution_fir.sv =====
// ----------------------------------------------------------------------------
// causal_convolution_fir
// Truncated causal convolution of a sample record with a loaded kernel.
//
//   Channel  Direction  Handshake           Payload
//   input    in         i_valid / o_ready   i_data (t_in_item)
//   output   out        o_valid / i_ready   o_data (t_out_item)
//
// A load or clear transaction is accepted in the idle state and leaves the
// block idle. A push walks the kernel and the record in the run state, waits
// in the drain state for the accumulation, and in the done state stores the
// result once the output register is free; the input is ready again after
// that. The walk is paced by the single multiply-accumulate unit that reads one kernel and one history entry a cycle.
// Reset is synchronous and active low; it empties the record, and the kernel
// memory holds no defined taps until they are loaded. A finished result waits
// in the output register, and the block takes new transactions meanwhile until
// the next result must be stored.
// ----------------------------------------------------------------------------
module causal_convolution_fir
    import cfir_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    t_state                   r_state;
    t_state                   n_state;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic [ADDR_W-1:0]        r_n;
    logic [ADDR_W-1:0]        n_n;
    logic [ADDR_W-1:0]        r_k;
    logic [ADDR_W-1:0]        n_k;
    t_mac_ctl                 r_rd_ctl;
    t_mac_ctl                 n_rd_ctl;
    logic                     r_out_valid;
    t_out_item                r_out;

    logic                     w_kern_we;
    logic                     w_hist_we;
    logic                     w_load_out;
    logic                     w_idx_ok;
    logic [TAP_W-1:0]         w_kern_rdata;
    logic [SMP_W-1:0]         w_hist_rdata;
    logic                     w_done;
    logic signed [OUT_W-1:0]  w_sum;

    assign w_idx_ok = {{(CMP_W - IDX_W){1'b0}}, i_data.tap_index} < CMP_W'(TAPS);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_n        = r_n;
        n_k        = r_k;
        n_rd_ctl   = '0;
        w_kern_we  = 1'b0;
        w_hist_we  = 1'b0;
        w_load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    unique case (i_data.command)
                        CMD_LOAD: begin
                            w_kern_we = w_idx_ok;
                        end
                        CMD_PUSH: begin
                            if (r_count < CNT_W'(TAPS)) begin
                                w_hist_we = 1'b1;
                                n_n       = ADDR_W'(r_count);
                                n_k       = '0;
                                n_count   = r_count + CNT_W'(1);
                                n_state   = S_RUN;
                            end
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RUN: begin
                n_rd_ctl.valid = 1'b1;
                n_rd_ctl.first = (r_k == '0);
                n_rd_ctl.last  = (r_k == r_n);
                n_k            = r_k + ADDR_W'(1);
                if (r_k == r_n) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (w_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_n         <= '0;
            r_k         <= '0;
            r_rd_ctl    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_n      <= n_n;
            r_k      <= n_k;
            r_rd_ctl <= n_rd_ctl;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out.filtered_value  <= w_sum;
            r_out.sample_position <= IDX_W'(r_n);
        end
    end

    cfir_ram #(
        .WIDTH (TAP_W),
        .DEPTH (TAPS)
    ) u_kernel_ram (
        .i_clk   (i_clk),
        .i_we    (w_kern_we),
        .i_waddr (ADDR_W'(i_data.tap_index)),
        .i_wdata (i_data.tap_value),
        .i_raddr (r_k),
        .o_rdata (w_kern_rdata)
    );

    cfir_ram #(
        .WIDTH (SMP_W),
        .DEPTH (TAPS)
    ) u_history_ram (
        .i_clk   (i_clk),
        .i_we    (w_hist_we),
        .i_waddr (ADDR_W'(r_count)),
        .i_wdata (i_data.sample_value),
        .i_raddr (r_n - r_k),
        .o_rdata (w_hist_rdata)
    );

    cfir_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (r_rd_ctl),
        .i_kernel ($signed(w_kern_rdata)),
        .i_sample (w_hist_rdata),
        .o_done   (w_done),
        .o_sum    (w_sum)
    );

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TAPS))
        else $error("Record count exceeds the number of taps.");

    a_read_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_ctl.valid |-> (r_state == S_RUN || r_state == S_DRAIN))
        else $error("Memory read data arrived outside a push walk.");

    a_done_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == S_DRAIN))
        else $error("Accumulation finished outside the drain state.");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_k <= r_n))
        else $error("Tap counter ran past the sample position.");
`endif

endmodule

// ===== tb/causal_convolution_fir_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// causal_convolution_fir_test
// Self-checking testbench for the causal convolution FIR filter.
//
// A scoreboard keeps its own kernel, sample history and record length. It
// works out the saturated convolution sum for every accepted push that finds
// the record not full and compares each output transaction with the oldest
// pending result. The stimulus starts with directed extremes. Random loads,
// pushes, clears and unused commands follow. Both sides stall at random, and
// once the output side holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module causal_convolution_fir_test;
    import cfir_pkg::*;

    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int TOTAL_ITEMS = 580;

    class fir_scoreboard;
        logic signed [TAP_W-1:0] kernel[TAPS];
        logic [SMP_W-1:0] history[TAPS];
        int unsigned taken;
        t_out_item expected_q[$];
        int errors, results, loads, pushes, clears, dropped, deepest;

        function new();
            foreach (kernel[i]) kernel[i] = '0;
            foreach (history[i]) history[i] = '0;
            taken = 0;
            errors = 0;
            results = 0;
            loads = 0;
            pushes = 0;
            clears = 0;
            dropped = 0;
            deepest = 0;
        endfunction

        function void note_input(t_in_item it);
            longint acc;
            int unsigned n;
            t_out_item r;
            case (it.command)
                CMD_LOAD: begin
                    loads++;
                    if (it.tap_index < TAPS) kernel[it.tap_index] = it.tap_value;
                end
                CMD_CLEAR: begin
                    clears++;
                    foreach (history[i]) history[i] = '0;
                    taken = 0;
                end
                CMD_PUSH: begin
                    if (taken >= TAPS) begin
                        dropped++;
                    end else begin
                        pushes++;
                        n = taken;
                        history[n] = it.sample_value;
                        acc = 0;
                        for (int k = 0; k <= n; k++) begin
                            acc += longint'(kernel[k]) * longint'(history[n - k]);
                        end
                        if (acc > longint'(OUT_MAX)) acc = longint'(OUT_MAX);
                        if (acc < longint'(OUT_MIN)) acc = longint'(OUT_MIN);
                        r.filtered_value = acc[OUT_W-1:0];
                        r.sample_position = n[IDX_W-1:0];
                        expected_q.push_back(r);
                        taken = n + 1;
                        if (taken > deepest) deepest = taken;
                    end
                end
                default: begin
                end
            endcase
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            results++;
            if (expected_q.size() == 0) begin
                $error("Unexpected result: filtered_value %0d, sample_position %0d",
                       got.filtered_value, got.sample_position);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.filtered_value !== want.filtered_value) begin
                $error("filtered_value: expected %0d, actual %0d",
                       want.filtered_value, got.filtered_value);
                errors++;
            end
            if (got.sample_position !== want.sample_position) begin
                $error("sample_position: expected %0d, actual %0d",
                       want.sample_position, got.sample_position);
                errors++;
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_item  i_data = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_item o_data;

    fir_scoreboard sb = new();
    int cycles = 0;
    int sent_items = 0;
    int unsigned rec_len = 0;
    bit tap_ready[TAPS];
    bit quiet = 1'b0;
    bit squeeze_req = 1'b0;

    causal_convolution_fir u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("causal_convolution_fir_test: errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) sb.check_result(o_data);
            if (i_valid && o_ready) sb.note_input(i_data);
        end
    end

    initial begin
        int stall, hold;
        bit held;
        stall = 0;
        hold = 0;
        held = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                i_ready <= 1'b0;
                hold--;
            end else if (squeeze_req && !held) begin
                held = 1'b1;
                hold = 2999;
                i_ready <= 1'b0;
            end else if (stall > 0) begin
                i_ready <= 1'b0;
                stall--;
            end else if (!quiet && (cycles / 700) % 4 != 3 && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(0, 4);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    function automatic t_in_item noise_item();
        logic [31:0] a, b;
        t_in_item it;
        a = $urandom();
        b = $urandom();
        it.command = a[1:0];
        it.tap_index = a[11:2];
        it.tap_value = a[27:12];
        it.sample_value = b[15:0];
        return it;
    endfunction

    function automatic logic signed [TAP_W-1:0] pick_tap();
        logic [31:0] r;
        r = $urandom();
        case (r[19:16])
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return r[15:0];
        endcase
    endfunction

    function automatic logic [SMP_W-1:0] pick_sample();
        logic [31:0] r;
        r = $urandom();
        case (r[19:16])
            0: return 16'hFFFF;
            1: return 16'h0000;
            2: return 16'h8000;
            3: return 16'h0001;
            default: return r[15:0];
        endcase
    endfunction

    function automatic int pick_record_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 24);
        if (r < 96) return $urandom_range(25, 100);
        return $urandom_range(101, 300);
    endfunction

    task automatic send_item(input t_in_item it);
        int gap;
        gap = 0;
        if (!quiet && (sent_items / 40) % 3 != 2 && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
        end
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_data <= it;
        do @(posedge i_clk); while (!o_ready);
        sent_items++;
    endtask

    task automatic issue(input t_in_item it);
        case (it.command)
            CMD_LOAD: tap_ready[it.tap_index] = 1'b1;
            CMD_PUSH: if (rec_len < TAPS) rec_len++;
            CMD_CLEAR: rec_len = 0;
            default: begin
            end
        endcase
        send_item(it);
    endtask

    task automatic load_tap(input logic [IDX_W-1:0] idx, input logic signed [TAP_W-1:0] val);
        t_in_item it;
        it = noise_item();
        it.command = CMD_LOAD;
        it.tap_index = idx;
        it.tap_value = val;
        issue(it);
    endtask

    task automatic push_sample(input logic [SMP_W-1:0] s);
        t_in_item it;
        if (rec_len < TAPS && !tap_ready[rec_len]) load_tap(rec_len[IDX_W-1:0], pick_tap());
        it = noise_item();
        it.command = CMD_PUSH;
        it.sample_value = s;
        issue(it);
    endtask

    task automatic clear_record();
        t_in_item it;
        it = noise_item();
        it.command = CMD_CLEAR;
        issue(it);
    endtask

    task automatic send_unused();
        t_in_item it;
        it = noise_item();
        it.command = CMD_NONE;
        issue(it);
    endtask

    initial begin
        int target, r;
        foreach (tap_ready[i]) tap_ready[i] = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        load_tap(10'd0, 16'sh7FFF);
        load_tap(10'd1, 16'sh8000);
        load_tap(10'd2, 16'sh0000);
        load_tap(10'd3, 16'shFFFF);
        load_tap(10'd4, 16'sh0001);
        push_sample(16'hFFFF);
        push_sample(16'hFFFF);
        push_sample(16'h0000);
        push_sample(16'hFFFF);
        push_sample(16'h0001);
        send_unused();
        load_tap(10'd1023, 16'sh5555);
        clear_record();
        push_sample(16'hFFFF);
        load_tap(10'd0, 16'sh8000);
        push_sample(16'h8000);
        push_sample(16'h0000);
        send_unused();
        clear_record();
        push_sample(16'h0000);

        target = pick_record_length();
        while (sent_items < TOTAL_ITEMS) begin
            r = $urandom_range(0, 99);
            if (rec_len >= target) begin
                clear_record();
                target = pick_record_length();
            end else if (r < 70) begin
                push_sample(pick_sample());
            end else if (r < 85) begin
                load_tap(IDX_W'($urandom_range(0, TAPS - 1)), pick_tap());
            end else if (r < 92) begin
                clear_record();
                target = pick_record_length();
            end else begin
                send_unused();
            end
            if (sent_items >= 200) squeeze_req = 1'b1;
            if (sent_items >= 500) quiet = 1'b1;
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (TAPS + 16) @(posedge i_clk);

        $display("Covered %0d tap loads, %0d samples, %0d clears, %0d pushes past a full record.",
                 sb.loads, sb.pushes, sb.clears, sb.dropped);
        $display("Checked %0d filtered outputs; longest record was %0d samples.",
                 sb.results, sb.deepest);
        if (sb.errors == 0) begin
            $display("causal_convolution_fir_test: clean");
        end else begin
            $display("causal_convolution_fir_test: errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/cfir_pkg.sv
hw/rtl/cfir_ram.sv
hw/rtl/cfir_mac.sv
hw/rtl/causal_convolution_fir.sv
tb/causal_convolution_fir_test.sv
